// ----- hdl/fct_pkg.sv -----
// Shared types and constants for the frustum culling block.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;
  localparam int PLANE_COUNT = 6;
  localparam int CRD_W = 16;
  localparam int COEF_W = 12;
  localparam int OFS_W = 28;
  localparam int DIST_W = 32;
  localparam int ADDR_W = 6;

  localparam logic [1:0] KIND_BOX = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_SEGMENT = 2'd2;
  localparam logic [1:0] KIND_TRIANGLE = 2'd3;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic [1:0] req_type;
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
  } query_t;

  // Item travelling down the chain of plane cells.
  typedef struct packed {
    logic valid;
    logic visible;
    query_t q;
  } flow_t;
endpackage
`default_nettype wire

// ----- hdl/fct_if.sv -----
// Valid/ready channel interface carrying a request payload.
`timescale 1ns / 1ps
`default_nettype none
interface fct_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/fct_cell.sv -----
// One plane cell: tests the passing request against one plane.
`timescale 1ns / 1ps
`default_nettype none
module fct_cell
  import fct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [63:0] plane,
  input  wire flow_t       flow_in,
  output flow_t            flow_out
);
  logic signed [COEF_W-1:0] a, b, c;
  logic signed [OFS_W-1:0] d;
  logic signed [DIST_W-1:0] dist0, dist1, dist2, distb;
  logic behind;
  flow_t flow_r, flow_nxt;

  function automatic logic signed [DIST_W-1:0] plane_dist(
      input logic signed [COEF_W-1:0] ka, kb, kc,
      input logic signed [OFS_W-1:0] kd,
      input logic signed [CRD_W-1:0] x, y, z);
    plane_dist = DIST_W'(ka * x) + DIST_W'(kb * y) + DIST_W'(kc * z) + DIST_W'(kd);
  endfunction

  always_comb begin
    a = plane[11:0];
    b = plane[23:12];
    c = plane[35:24];
    d = plane[63:36];
    dist0 = plane_dist(a, b, c, d, flow_in.q.v0.x, flow_in.q.v0.y, flow_in.q.v0.z);
    dist1 = plane_dist(a, b, c, d, flow_in.q.v1.x, flow_in.q.v1.y, flow_in.q.v1.z);
    dist2 = plane_dist(a, b, c, d, flow_in.q.v2.x, flow_in.q.v2.y, flow_in.q.v2.z);
    // Positive vertex: max corner where the coefficient is positive.
    distb = plane_dist(a, b, c, d,
                       (a > 0) ? flow_in.q.v1.x : flow_in.q.v0.x,
                       (b > 0) ? flow_in.q.v1.y : flow_in.q.v0.y,
                       (c > 0) ? flow_in.q.v1.z : flow_in.q.v0.z);
    case (flow_in.q.req_type)
      KIND_BOX:      behind = distb[DIST_W-1];
      KIND_POINT:    behind = dist0[DIST_W-1];
      KIND_SEGMENT:  behind = dist0[DIST_W-1] & dist1[DIST_W-1];
      KIND_TRIANGLE: behind = dist0[DIST_W-1] & dist1[DIST_W-1] & dist2[DIST_W-1];
      default:       behind = 1'b0;
    endcase
    flow_nxt = flow_in;
    flow_nxt.visible = flow_in.visible & ~behind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_r.valid <= 1'b0;
    end else if (en) begin
      flow_r.valid <= flow_nxt.valid;
    end
    if (en) begin
      flow_r.visible <= flow_nxt.visible;
      flow_r.q <= flow_nxt.q;
    end
  end

  assign flow_out = flow_r;
endmodule
`default_nettype wire

// ----- hdl/fct_regs.sv -----
// APB-style register file holding the plane coefficients.
`timescale 1ns / 1ps
`default_nettype none
module fct_regs
  import fct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic [PLANE_COUNT-1:0][63:0] planes
);
  logic [PLANE_COUNT-1:0][63:0] plane_r;
  logic [2:0] idx;

  assign idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0
                 && 32'(idx) < PLANE_COUNT) begin
      plane_r[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (32'(idx) == i) prdata = plane_r[i];
    end
  end

  assign planes = plane_r;
endmodule
`default_nettype wire

// ----- hdl/frustum_cull_test.sv -----
// Top level of the frustum culling block: register file and plane cell chain.
//   channel  direction  payload
//   in_      sink       req_type, v0..v2 xyz
//   out_     source     visible
//   cfg_     APB slave  plane_0..plane_5, 64-bit at 8*i
// One request enters per cycle while the chain is not halted; it passes through
// the registered plane cells in turn. The whole chain advances together and halts
// when the last stage holds a result that is not taken; bubbles inside the
// chain are not squeezed out during a halt.
// Synchronous active-low reset empties the chain and clears the planes.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_test
  import fct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  fct_if.sink                    in_ch,
  fct_if.source                  out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [63:0]       cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [PLANE_COUNT-1:0][63:0] planes;
  flow_t chain [PLANE_COUNT+1];
  logic en;

  assign cfg_pready = 1'b1;

  fct_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .planes(planes)
  );

  // The chain moves when its last stage is empty or being drained.
  assign en = ~chain[PLANE_COUNT].valid | out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    chain[0].valid = in_ch.valid;
    chain[0].visible = 1'b1;
    chain[0].q = query_t'(in_ch.data);
  end

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    fct_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .plane(planes[g]),
      .flow_in(chain[g]), .flow_out(chain[g+1])
    );
  end

  assign out_ch.valid = chain[PLANE_COUNT].valid;
  assign out_ch.data = chain[PLANE_COUNT].visible;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken while chain is stalled");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered straight after reset");
endmodule
`default_nettype wire

// ----- test/frustum_cull_test_tb.sv -----
// Self-checking testbench for the frustum culling block.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_test_tb;
  import fct_pkg::*;

  localparam int QW = $bits(query_t);
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  fct_if #(.W(QW)) in_ch ();
  fct_if #(.W(1)) out_ch ();

  frustum_cull_test i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [63:0] plane_regs [PLANE_COUNT];
  logic expected_visible [$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;
  int hold_off = 0;

  // Exact sign test of a*x+b*y+c*z+d for one plane.
  function automatic logic signed [63:0] plane_distance(logic [63:0] r, vtx_t p);
    logic signed [63:0] a, b, c, d;
    a = 64'(signed'(r[11:0]));
    b = 64'(signed'(r[23:12]));
    c = 64'(signed'(r[35:24]));
    d = 64'(signed'(r[63:36]));
    return a * 64'(p.x) + b * 64'(p.y) + c * 64'(p.z) + d;
  endfunction

  function automatic logic predict_visible(query_t q);
    vtx_t pv;
    logic behind;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (q.req_type == KIND_BOX) begin
        pv.x = ($signed(plane_regs[i][11:0]) > 0) ? q.v1.x : q.v0.x;
        pv.y = ($signed(plane_regs[i][23:12]) > 0) ? q.v1.y : q.v0.y;
        pv.z = ($signed(plane_regs[i][35:24]) > 0) ? q.v1.z : q.v0.z;
        behind = plane_distance(plane_regs[i], pv) < 0;
      end else begin
        behind = plane_distance(plane_regs[i], q.v0) < 0;
        if (q.req_type != KIND_POINT)
          behind = behind && plane_distance(plane_regs[i], q.v1) < 0;
        if (q.req_type == KIND_TRIANGLE)
          behind = behind && plane_distance(plane_regs[i], q.v2) < 0;
      end
      if (behind) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic write_plane(int idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(8 * idx);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx < PLANE_COUNT) plane_regs[idx] = value;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_visible.size() != 0) @(posedge clk);
    repeat (PLANE_COUNT + 4) @(posedge clk);
  endtask

  task automatic send_query(query_t q);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_visible.push_back(predict_visible(q));
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  function automatic vtx_t rand_vertex(int span);
    vtx_t v;
    if (span >= 32767) begin
      v.x = 16'($urandom); v.y = 16'($urandom); v.z = 16'($urandom);
    end else begin
      v.x = 16'($urandom_range(0, 2 * span) - span);
      v.y = 16'($urandom_range(0, 2 * span) - span);
      v.z = 16'($urandom_range(0, 2 * span) - span);
    end
    return v;
  endfunction

  // Planes near the origin so that queries fall on both sides.
  function automatic logic [63:0] rand_plane(int dspan);
    logic [63:0] r;
    logic signed [27:0] d;
    r = {$urandom, $urandom};
    d = 28'($urandom_range(0, 2 * dspan) - dspan);
    r[63:36] = d;
    return r;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int span;
    span = ($urandom_range(0, 9) == 0) ? 32767 : 2000;
    q.req_type = 2'($urandom_range(0, 3));
    q.v0 = rand_vertex(span);
    q.v1 = rand_vertex(span);
    q.v2 = rand_vertex(span);
    return q;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_visible.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result visible=%0b", out_ch.data[0]);
      end else begin
        logic exp_v;
        exp_v = expected_visible.pop_front();
        if (out_ch.data[0] !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("visible mismatch: expected %0b got %0b", exp_v, out_ch.data[0]);
        end
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 9);
        repeat (stall) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_reset_planes();
    query_t q;
    // With every plane cleared nothing is culled.
    for (int k = 0; k < 4; k++) begin
      q = rand_query();
      q.req_type = 2'(k);
      send_query(q);
    end
    end_burst();
    wait_drained();
  endtask

  task automatic test_directed();
    query_t q;
    // Plane 0 keeps x >= 0: a = 1.0, the rest zero.
    write_plane(0, 64'h400);
    for (int i = 1; i < PLANE_COUNT; i++) write_plane(i, 64'h0);
    q = '0;
    q.req_type = KIND_POINT; q.v0.x = -16'sd1; send_query(q);
    q.v0.x = 16'sd0; send_query(q);
    q.v0.x = 16'sh7fff; q.v1.x = -16'sh8000; send_query(q);
    q.v0.x = -16'sh8000; send_query(q);
    q.req_type = KIND_SEGMENT; q.v0.x = -16'sd5; q.v1.x = -16'sd3; send_query(q);
    q.v1.x = 16'sd3; send_query(q);
    q.req_type = KIND_TRIANGLE; q.v1.x = -16'sd3; q.v2.x = 16'sd2; send_query(q);
    q.v2.x = -16'sd2; send_query(q);
    q.req_type = KIND_SEGMENT; q.v2.x = 16'sd100; send_query(q);
    q.req_type = KIND_BOX; q.v0.x = -16'sd10; q.v1.x = -16'sd1; send_query(q);
    q.v1.x = 16'sd0; send_query(q);
    // Inverted box: max below min, vertex picked by sign only.
    q.v0.x = 16'sd5; q.v1.x = -16'sd5; send_query(q);
    q.v0.x = -16'sd5; q.v1.x = 16'sd5; send_query(q);
    end_burst();
    wait_drained();
    // Extreme coefficients and offsets on the last plane.
    write_plane(0, 64'h0);
    write_plane(PLANE_COUNT - 1, {28'h8000000, 12'h800, 12'h800, 12'h800});
    q = '0;
    q.req_type = KIND_POINT; q.v0 = '{-16'sh8000, -16'sh8000, -16'sh8000}; send_query(q);
    q.v0 = '{16'sh7fff, 16'sh7fff, 16'sh7fff}; send_query(q);
    q.req_type = KIND_BOX; q.v1 = '{-16'sh8000, -16'sh8000, -16'sh8000}; send_query(q);
    end_burst();
    wait_drained();
    write_plane(PLANE_COUNT - 1, {28'h7ffffff, 12'h7ff, 12'h7ff, 12'h7ff});
    q.req_type = KIND_TRIANGLE; send_query(q);
    q.req_type = KIND_BOX; send_query(q);
    q.v0 = '{-16'sh8000, -16'sh8000, -16'sh8000}; q.req_type = KIND_POINT; send_query(q);
    end_burst();
    wait_drained();
  endtask

  task automatic test_random(int count, int dspan);
    for (int i = 0; i < PLANE_COUNT; i++) write_plane(i, rand_plane(dspan));
    for (int n = 0; n < count; n++) send_query(rand_query());
    end_burst();
    wait_drained();
  endtask

  task automatic test_backpressure();
    // Results held back for a long stretch while requests keep coming.
    hold_off = 60;
    for (int n = 0; n < 40; n++) send_query(rand_query());
    end_burst();
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_planes();
    test_directed();
    test_random(150, 2000000);
    test_random(150, 200000);
    test_backpressure();
    test_random(150, 134217727);
    idle_enable = 1'b0;
    test_random(180, 1000000);
    if (mismatches == 0 && expected_visible.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
